### rtl/core/rit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_pkg
// Shared types, constants and helpers for the radix integer-to-text block.
// ----------------------------------------------------------------------------
package rit_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_ALPHABET_LOW  = 2'd1;
    localparam logic [1:0] CFG_ALPHABET_HIGH = 2'd2;

    localparam int unsigned RIT_STEP_BITS  = 4;   // quotient bits per divider cycle
    localparam int unsigned RIT_MAX_DIGITS = 32;
    localparam int unsigned RIT_SYMBOLS    = 16;

    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_HIGH  = 8'd128;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic       we;
        logic [4:0] waddr;
        logic [3:0] wdata;
        logic       re;
        logic [4:0] raddr;
    } t_store_req;

    function automatic logic [7:0] symbol_at(input logic [3:0] idx, input logic [127:0] alpha);
        symbol_at = alpha[{idx, 3'b000} +: 8];
    endfunction

    // true when the first len symbols form a usable digit alphabet
    function automatic logic alphabet_ok(input logic [4:0]   len,
                                         input logic [4:0]   max_base,
                                         input logic [127:0] alpha);
        logic       ok;
        logic [7:0] ci;
        logic [7:0] cj;
        ok = (len >= 5'd2) && (len <= max_base) && (len <= 5'(RIT_SYMBOLS));
        for (int i = 0; i < RIT_SYMBOLS; i++) begin
            ci = alpha[i*8 +: 8];
            if (5'(i) < len) begin
                if (ci == CHAR_PLUS || ci == CHAR_MINUS || ci <= CHAR_SPACE || ci >= CHAR_HIGH)
                    ok = 1'b0;
                for (int j = i + 1; j < RIT_SYMBOLS; j++) begin
                    cj = alpha[j*8 +: 8];
                    if (5'(j) < len && cj == ci)
                        ok = 1'b0;
                end
            end
        end
        alphabet_ok = ok;
    endfunction

endpackage

### rtl/core/rit_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_div
// Iterative restoring divider by a small radix, four quotient bits a cycle.
// ----------------------------------------------------------------------------
module rit_div #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rit_pkg::t_div_ctrl    i_ctrl,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [4:0]            i_radix,
    output rit_pkg::t_div_stat    o_stat,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [3:0]            o_remainder
);
    localparam int STEP     = rit_pkg::RIT_STEP_BITS;
    localparam int PAD_BITS = ((VALUE_BITS + STEP - 1) / STEP) * STEP;
    localparam int STEPS    = PAD_BITS / STEP;
    localparam int CNT_W    = $clog2(STEPS + 1);

    logic [PAD_BITS-1:0] r_quo, n_quo;
    logic [3:0]          r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_done;

    // dividend bits leave at the top while quotient bits enter at the bottom
    always_comb begin
        logic [4:0]          t;
        logic [PAD_BITS-1:0] w;
        logic [3:0]          rm;
        w  = r_quo;
        rm = r_rem;
        for (int j = 0; j < STEP; j++) begin
            t = {rm, w[PAD_BITS-1]};
            w = {w[PAD_BITS-2:0], 1'b0};
            if (t >= i_radix) begin
                t    = t - i_radix;
                w[0] = 1'b1;
            end
            rm = t[3:0];
        end
        n_quo = w;
        n_rem = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_ctrl.start) begin
            r_cnt  <= CNT_W'(STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_quo <= PAD_BITS'(i_dividend);
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo[VALUE_BITS-1:0];
    assign o_remainder = r_rem;

endmodule

### rtl/core/rit_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_store
// Digit store: 32 entries of one digit index, registered read.
// ----------------------------------------------------------------------------
module rit_store (
    input  logic                i_clk,
    input  rit_pkg::t_store_req i_req,
    output logic [3:0]          o_rdata
);
    logic [3:0] r_mem [rit_pkg::RIT_MAX_DIGITS];
    logic [3:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we)
            r_mem[i_req.waddr] <= i_req.wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re)
            r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/radix_integer_to_text.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_to_text
// Writes a signed integer as text in a configurable radix, one character a beat.
// ----------------------------------------------------------------------------
// One value is taken at a time; o_ready is high only while the block is idle.
// After a value is taken, the ST_CHECK state checks the alphabet (a bad
// alphabet gives no beats and the block is ready again on the next cycle).
// Each digit then passes through the shared divider, which retires four
// quotient bits a cycle, and each output character takes a digit store read,
// then an output register load, plus stall time on the output. A negative
// value first emits the sign.
// Configuration is written through a plain write port; the user must write it
// only while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module radix_integer_to_text #(
    parameter int MAX_BASE   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input beats
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_value,
    // output beats
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_out_char,
    output logic                         o_last,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [63:0]                  i_cfg_data
);
    rit_pkg::t_state     r_state, n_state;
    logic [4:0]          r_base_length;
    logic [63:0]         r_alpha_low;
    logic [63:0]         r_alpha_high;
    logic [VALUE_BITS-1:0] r_value;
    logic                r_neg, n_neg;
    logic [5:0]          r_count, n_count;
    logic                r_out_valid;
    logic [7:0]          r_out_char;
    logic                r_out_last;

    logic [127:0]        alpha;
    logic                alpha_ok;
    logic                neg;
    logic [VALUE_BITS-1:0] mag;
    logic                out_free;
    logic                load_out;
    logic [7:0]          load_char;
    logic                load_last;

    rit_pkg::t_div_ctrl  div_ctrl;
    rit_pkg::t_div_stat  div_stat;
    logic [VALUE_BITS-1:0] dividend;
    logic [VALUE_BITS-1:0] quotient;
    logic [3:0]          remainder;
    rit_pkg::t_store_req store_req;
    logic [3:0]          store_rdata;

    assign alpha    = {r_alpha_high, r_alpha_low};
    assign alpha_ok = rit_pkg::alphabet_ok(r_base_length, 5'(MAX_BASE), alpha);
    assign neg      = r_value[VALUE_BITS-1];
    assign mag      = neg ? (~r_value + VALUE_BITS'(1)) : r_value;
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length <= '0;
            r_alpha_low   <= '0;
            r_alpha_high  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rit_pkg::CFG_BASE_LENGTH:   r_base_length <= i_cfg_data[4:0];
                rit_pkg::CFG_ALPHABET_LOW:  r_alpha_low   <= i_cfg_data;
                rit_pkg::CFG_ALPHABET_HIGH: r_alpha_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rit_pkg::ST_IDLE;
            r_neg   <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_neg   <= n_neg;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready)
            r_value <= i_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_char <= load_char;
            r_out_last <= load_last;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_count   = r_count;
        o_ready   = 1'b0;
        div_ctrl  = '0;
        dividend  = mag;
        store_req = '0;
        load_out  = 1'b0;
        load_char = '0;
        load_last = 1'b0;
        case (r_state)
            rit_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid)
                    n_state = rit_pkg::ST_CHECK;
            end
            rit_pkg::ST_CHECK: begin
                if (!alpha_ok) begin
                    n_state = rit_pkg::ST_IDLE;
                end else begin
                    n_neg          = neg;
                    n_count        = '0;
                    div_ctrl.start = 1'b1;
                    n_state        = rit_pkg::ST_DIVIDE;
                end
            end
            rit_pkg::ST_DIVIDE: begin
                if (div_stat.done) begin
                    store_req.we    = 1'b1;
                    store_req.waddr = r_count[4:0];
                    store_req.wdata = remainder;
                    n_count         = r_count + 6'd1;
                    if (quotient != '0 && n_count < 6'(rit_pkg::RIT_MAX_DIGITS)) begin
                        div_ctrl.start = 1'b1;
                        dividend       = quotient;
                    end else begin
                        n_state = r_neg ? rit_pkg::ST_SIGN : rit_pkg::ST_FETCH;
                    end
                end
            end
            rit_pkg::ST_SIGN: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    load_char = rit_pkg::CHAR_MINUS;
                    n_state   = rit_pkg::ST_FETCH;
                end
            end
            rit_pkg::ST_FETCH: begin
                // r_count now walks down as the emit index
                store_req.re    = 1'b1;
                n_count         = r_count - 6'd1;
                store_req.raddr = n_count[4:0];
                n_state         = rit_pkg::ST_SEND;
            end
            rit_pkg::ST_SEND: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    load_char = rit_pkg::symbol_at(store_rdata, alpha);
                    load_last = (r_count == '0);
                    n_state   = (r_count == '0) ? rit_pkg::ST_IDLE : rit_pkg::ST_FETCH;
                end
            end
            default: n_state = rit_pkg::ST_IDLE;
        endcase
    end

    rit_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (dividend),
        .i_radix    (r_base_length),
        .o_stat     (div_stat),
        .o_quotient (quotient),
        .o_remainder(remainder)
    );

    rit_store u_store (
        .i_clk  (i_clk),
        .i_req  (store_req),
        .o_rdata(store_rdata)
    );

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

    // divider is only kicked while checking or dividing
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_ctrl.start |-> (r_state == rit_pkg::ST_CHECK || r_state == rit_pkg::ST_DIVIDE))
        else $error("divider started outside divide phase");

    // no new value while the divider still runs
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !div_stat.busy)
        else $error("ready while divider busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 6'(rit_pkg::RIT_MAX_DIGITS))
        else $error("digit count out of range");

    // loading the final character returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && load_last) |=> (r_state == rit_pkg::ST_IDLE))
        else $error("last beat loaded without returning to idle");

endmodule
